[hdl/spimsp_pkg.sv]
package spimsp_pkg;

   // event codes on the request channel
   typedef enum logic [1:0] {
      MODE_START    = 2'd0,
      MODE_BYTE     = 2'd1,
      MODE_TEMP_REQ = 2'd2,
      MODE_NONE     = 2'd3
   } mode_type;

   // register map
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_FILL_BYTE = 1'b0;
   localparam logic [7:0] FILL_BYTE_RESET = 8'h11;

   // chip select bit positions
   localparam int SEL_TEMP1  = 0;
   localparam int SEL_TEMP2  = 1;
   localparam int SEL_SPEED1 = 2;
   localparam int SEL_SPEED2 = 3;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]  chip_selects_n;
      logic        master_select_n;
      logic        start_transfer;
      logic [7:0]  tx_byte;
      logic [15:0] speed_one;
      logic [15:0] speed_two;
      logic [12:0] temp_one;
      logic [12:0] temp_two;
      logic        speed_done;
      logic        temp_done;
   } rsp_type;

endpackage

[hdl/spimsp_engine.sv]
module spimsp_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  spimsp_pkg::req_type req,
   input  logic [7:0]          fill_byte,
   output spimsp_pkg::rsp_type result
);

   logic [1:0]       byte_index_ff, byte_index_in;
   logic             in_temp_ff, in_temp_in;
   logic             temp_pending_ff, temp_pending_in;
   logic [3:0]       select_ff, select_in;
   logic             master_ff, master_in;
   logic [3:0][7:0]  speed_ff, speed_in;
   logic [3:0][7:0]  temp_ff, temp_in;
   logic [2:0]       next_idx;
   logic             go, sdone, tdone;

   // next sequencer state for the current event
   always_comb begin
      byte_index_in   = byte_index_ff;
      in_temp_in      = in_temp_ff;
      temp_pending_in = temp_pending_ff;
      select_in       = select_ff;
      master_in       = master_ff;
      speed_in        = speed_ff;
      temp_in         = temp_ff;
      go              = 1'b0;
      sdone           = 1'b0;
      tdone           = 1'b0;
      next_idx        = {1'b0, byte_index_ff} + 3'd1;
      unique case (spimsp_pkg::mode_type'(req.mode))
         spimsp_pkg::MODE_START: begin
            master_in = 1'b0;
            select_in[spimsp_pkg::SEL_SPEED1] = 1'b0;
            go = 1'b1;
         end
         spimsp_pkg::MODE_TEMP_REQ: begin
            temp_pending_in = 1'b1;
         end
         spimsp_pkg::MODE_BYTE: begin
            if (in_temp_ff) begin
               temp_in[byte_index_ff] = req.rx_byte;
               if (next_idx == 3'd2) begin
                  select_in[spimsp_pkg::SEL_TEMP1] = 1'b1;
                  select_in[spimsp_pkg::SEL_TEMP2] = 1'b0;
               end
               if (next_idx == 3'd4) begin
                  select_in[spimsp_pkg::SEL_TEMP2] = 1'b1;
                  master_in       = 1'b1;
                  temp_pending_in = 1'b0;
                  in_temp_in      = 1'b0;
                  tdone           = 1'b1;
               end else begin
                  go = 1'b1;
               end
            end else begin
               speed_in[byte_index_ff] = req.rx_byte;
               if (next_idx == 3'd2) begin
                  select_in[spimsp_pkg::SEL_SPEED1] = 1'b1;
                  select_in[spimsp_pkg::SEL_SPEED2] = 1'b0;
               end
               if (next_idx == 3'd4) begin
                  select_in[spimsp_pkg::SEL_SPEED2] = 1'b1;
                  sdone = 1'b1;
                  if (temp_pending_ff) begin
                     select_in[spimsp_pkg::SEL_TEMP1] = 1'b0;
                     in_temp_in = 1'b1;
                     go = 1'b1;
                  end else begin
                     master_in = 1'b1;
                  end
               end else begin
                  go = 1'b1;
               end
            end
            // wraps to zero after the fourth byte
            byte_index_in = next_idx[1:0];
         end
         spimsp_pkg::MODE_NONE: begin
         end
         default: begin
         end
      endcase
   end

   // result fields from the updated state
   always_comb begin
      result.chip_selects_n  = select_in;
      result.master_select_n = master_in;
      result.start_transfer  = go;
      result.tx_byte         = fill_byte;
      result.speed_one       = {speed_in[1], speed_in[0]};
      result.speed_two       = {speed_in[3], speed_in[2]};
      result.temp_one        = {temp_in[0], temp_in[1][7:3]};
      result.temp_two        = {temp_in[2], temp_in[3][7:3]};
      result.speed_done      = sdone;
      result.temp_done       = tdone;
   end

   // sequencer state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff   <= '0;
         in_temp_ff      <= 1'b0;
         temp_pending_ff <= 1'b0;
         select_ff       <= 4'hF;
         master_ff       <= 1'b1;
         speed_ff        <= '0;
         temp_ff         <= '0;
      end else if (accept) begin
         byte_index_ff   <= byte_index_in;
         in_temp_ff      <= in_temp_in;
         temp_pending_ff <= temp_pending_in;
         select_ff       <= select_in;
         master_ff       <= master_in;
         speed_ff        <= speed_in;
         temp_ff         <= temp_in;
      end
   end

endmodule

[hdl/spi_multi_sensor_poll_sequencer.sv]
// Poll sequencer for two speed sensors and two thermocouple converters
// that share one external SPI byte shifter.
// Request channel (req_valid, req_stall, req_data): one event per
// transaction: start a burst, byte completed with the received byte, or
// request a thermocouple read.
// Response channel (rsp_valid, rsp_stall, rsp_data): exactly one result
// per event, carrying chip selects, master select, transfer request,
// transmit byte, decoded speed and temperature words and done pulses.
// The result is registered: the result of an event accepted at one edge
// is valid after that edge. One event is taken per cycle while no held
// result is stalled; the state update and decode sit between the
// sequencer registers and the result register.
// When the receiver stalls, the result register holds and req_stall is
// raised until that result is taken; a result taken in the same cycle
// lets a new event in.
// csr port: fill_byte at addresses 0-3, written by a completed write access.
// Reset deselects all chips and the master line, clears the captured
// bytes and the pending flag, and sets fill_byte to 0x11.
module spi_multi_sensor_poll_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  spimsp_pkg::req_type                 req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output spimsp_pkg::rsp_type                 rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [spimsp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   logic                fill_write;
   logic [7:0]          fill_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   spimsp_pkg::rsp_type rsp_ff;
   spimsp_pkg::rsp_type result;
   logic                accept;
   logic                csr_hit;

   // register decode
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == spimsp_pkg::CSR_IDX_FILL_BYTE);
   assign csr_prdata = csr_hit ? {24'd0, fill_ff} : 32'd0;
   assign fill_write = csr_psel && csr_penable && csr_pwrite && csr_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= spimsp_pkg::FILL_BYTE_RESET;
      end else if (fill_write) begin
         fill_ff <= csr_pwdata[7:0];
      end
   end

   // handshake: the result register frees when its result is taken
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   spimsp_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .fill_byte (fill_ff),
      .result    (result)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[dv/testbench.sv]
module testbench;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   spimsp_pkg::req_type               req_data = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   spimsp_pkg::rsp_type               rsp_data;
   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [spimsp_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]                       csr_pwdata = '0;
   logic [31:0]                       csr_prdata;
   logic                              csr_pready;

   // mirror of the sequencer state
   logic [7:0] mirror_fill;
   logic [1:0] mirror_index;
   logic       mirror_in_temp;
   logic       mirror_pending;
   logic [3:0] mirror_selects;
   logic       mirror_master;
   logic [7:0] mirror_speed_bytes [4];
   logic [7:0] mirror_temp_bytes [4];

   spimsp_pkg::rsp_type awaited_results [$];
   int      mismatch_count = 0;
   int      events_sent = 0;
   int      send_idle_pct = 0;
   int      stall_pct = 0;

   spi_multi_sensor_poll_sequencer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #2 clock = ~clock;

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // apply one event to the mirror and form the result it causes
   function automatic spimsp_pkg::rsp_type advance_poll(input spimsp_pkg::req_type ev);
      spimsp_pkg::rsp_type r;
      logic [2:0]  nxt;
      logic        go;
      logic        sdone;
      logic        tdone;
      logic [15:0] word;
      nxt = {1'b0, mirror_index} + 3'd1;
      go = 1'b0;
      sdone = 1'b0;
      tdone = 1'b0;
      case (ev.mode)
         spimsp_pkg::MODE_START: begin
            mirror_master = 1'b0;
            mirror_selects[spimsp_pkg::SEL_SPEED1] = 1'b0;
            go = 1'b1;
         end
         spimsp_pkg::MODE_TEMP_REQ: begin
            mirror_pending = 1'b1;
         end
         spimsp_pkg::MODE_BYTE: begin
            if (mirror_in_temp) begin
               mirror_temp_bytes[mirror_index] = ev.rx_byte;
               if (nxt == 3'd2) begin
                  mirror_selects[spimsp_pkg::SEL_TEMP1] = 1'b1;
                  mirror_selects[spimsp_pkg::SEL_TEMP2] = 1'b0;
               end
               if (nxt == 3'd4) begin
                  mirror_selects[spimsp_pkg::SEL_TEMP2] = 1'b1;
                  mirror_master = 1'b1;
                  mirror_pending = 1'b0;
                  mirror_in_temp = 1'b0;
                  tdone = 1'b1;
                  nxt = 3'd0;
               end else begin
                  go = 1'b1;
               end
            end else begin
               mirror_speed_bytes[mirror_index] = ev.rx_byte;
               if (nxt == 3'd2) begin
                  mirror_selects[spimsp_pkg::SEL_SPEED1] = 1'b1;
                  mirror_selects[spimsp_pkg::SEL_SPEED2] = 1'b0;
               end
               if (nxt == 3'd4) begin
                  mirror_selects[spimsp_pkg::SEL_SPEED2] = 1'b1;
                  sdone = 1'b1;
                  nxt = 3'd0;
                  // pending thermocouple read chains straight on
                  if (mirror_pending) begin
                     mirror_selects[spimsp_pkg::SEL_TEMP1] = 1'b0;
                     mirror_in_temp = 1'b1;
                     go = 1'b1;
                  end else begin
                     mirror_master = 1'b1;
                  end
               end else begin
                  go = 1'b1;
               end
            end
            mirror_index = nxt[1:0];
         end
         default: begin
         end
      endcase
      r.chip_selects_n = mirror_selects;
      r.master_select_n = mirror_master;
      r.start_transfer = go;
      r.tx_byte = mirror_fill;
      r.speed_one = {mirror_speed_bytes[1], mirror_speed_bytes[0]};
      r.speed_two = {mirror_speed_bytes[3], mirror_speed_bytes[2]};
      word = {mirror_temp_bytes[0], mirror_temp_bytes[1]};
      r.temp_one = word[15:3];
      word = {mirror_temp_bytes[2], mirror_temp_bytes[3]};
      r.temp_two = word[15:3];
      r.speed_done = sdone;
      r.temp_done = tdone;
      return r;
   endfunction

   // one event transaction, mirrored once it is accepted
   task automatic send_event(input spimsp_pkg::mode_type m, input logic [7:0] rx);
      spimsp_pkg::req_type ev;
      ev.mode = m;
      ev.rx_byte = rx;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = ev;
      do @(posedge clock); while (req_stall);
      awaited_results.push_back(advance_poll(ev));
      events_sent++;
   endtask

   // stop sending and let every pending result come back
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // write fill_byte, then read it back
   task automatic program_fill_byte(input logic [7:0] value);
      drain_results();
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {spimsp_pkg::CSR_IDX_FILL_BYTE, 2'b00};
      csr_pwdata = {24'($urandom_range(32'hFF_FFFF)), value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      mirror_fill = value;
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {24'h0, value}) begin
         $display("%0t: fill_byte readback expected %h actual %h",
                  $time, {24'h0, value}, csr_prdata);
         mismatch_count++;
      end
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   // start, four speed bytes with requests sprinkled in, then any thermocouple bytes
   task automatic send_poll_burst();
      send_event(spimsp_pkg::MODE_START, 8'($urandom));
      for (int k = 0; k < 4; k++) begin
         if ($urandom_range(3) == 0) begin
            send_event(spimsp_pkg::MODE_TEMP_REQ, 8'($urandom));
         end
         send_event(spimsp_pkg::MODE_BYTE, 8'($urandom));
      end
      while (mirror_in_temp) begin
         send_event(spimsp_pkg::MODE_BYTE, 8'($urandom));
      end
   endtask

   task automatic test_directed_sequences();
      send_event(spimsp_pkg::MODE_BYTE, 8'h00);
      send_event(spimsp_pkg::MODE_NONE, 8'hFF);
      send_event(spimsp_pkg::MODE_START, 8'h00);
      send_event(spimsp_pkg::MODE_BYTE, 8'hFF);
      send_event(spimsp_pkg::MODE_BYTE, 8'h80);
      send_event(spimsp_pkg::MODE_BYTE, 8'h01);
      send_event(spimsp_pkg::MODE_TEMP_REQ, 8'h00);
      send_event(spimsp_pkg::MODE_TEMP_REQ, 8'hFF);
      send_event(spimsp_pkg::MODE_START, 8'hFF);
      send_event(spimsp_pkg::MODE_BYTE, 8'hFF);
      send_event(spimsp_pkg::MODE_BYTE, 8'hFF);
      send_event(spimsp_pkg::MODE_BYTE, 8'hFF);
      send_event(spimsp_pkg::MODE_BYTE, 8'hA5);
      // start arriving once the chained thermocouple burst has begun, before its first byte
      send_event(spimsp_pkg::MODE_START, 8'h5A);
      send_event(spimsp_pkg::MODE_BYTE, 8'hFF);
      send_event(spimsp_pkg::MODE_BYTE, 8'hF8);
      send_event(spimsp_pkg::MODE_BYTE, 8'h00);
      send_event(spimsp_pkg::MODE_BYTE, 8'h07);
      send_event(spimsp_pkg::MODE_NONE, 8'h00);
   endtask

   task automatic test_fill_byte_extremes();
      program_fill_byte(8'h00);
      send_event(spimsp_pkg::MODE_START, 8'h00);
      send_event(spimsp_pkg::MODE_BYTE, 8'h3C);
      program_fill_byte(8'hFF);
      send_event(spimsp_pkg::MODE_BYTE, 8'hC3);
      send_event(spimsp_pkg::MODE_NONE, 8'h00);
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_chance,
                                      input int item_count);
      int target;
      program_fill_byte(8'($urandom));
      send_idle_pct = idle_pct;
      stall_pct = stall_chance;
      target = events_sent + item_count;
      while (events_sent < target) begin
         if ($urandom_range(99) < 85) begin
            send_poll_burst();
         end else begin
            send_event(spimsp_pkg::mode_type'($urandom_range(3)), 8'($urandom));
         end
      end
   endtask

   // compare each accepted result against the oldest expectation
   function automatic void check_field(input string name, input logic [15:0] got,
                                       input logic [15:0] want);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      spimsp_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result expected none actual %h", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = awaited_results.pop_front();
            check_field("chip_selects_n", 16'(rsp_data.chip_selects_n),
                        16'(want.chip_selects_n));
            check_field("master_select_n", 16'(rsp_data.master_select_n),
                        16'(want.master_select_n));
            check_field("start_transfer", 16'(rsp_data.start_transfer),
                        16'(want.start_transfer));
            check_field("tx_byte", 16'(rsp_data.tx_byte), 16'(want.tx_byte));
            check_field("speed_one", rsp_data.speed_one, want.speed_one);
            check_field("speed_two", rsp_data.speed_two, want.speed_two);
            check_field("temp_one", 16'(rsp_data.temp_one), 16'(want.temp_one));
            check_field("temp_two", 16'(rsp_data.temp_two), 16'(want.temp_two));
            check_field("speed_done", 16'(rsp_data.speed_done), 16'(want.speed_done));
            check_field("temp_done", 16'(rsp_data.temp_done), 16'(want.temp_done));
         end
      end
   end

   // run limit
   initial begin
      #800000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      mirror_fill = spimsp_pkg::FILL_BYTE_RESET;
      mirror_index = 2'd0;
      mirror_in_temp = 1'b0;
      mirror_pending = 1'b0;
      mirror_selects = 4'hF;
      mirror_master = 1'b1;
      for (int i = 0; i < 4; i++) begin
         mirror_speed_bytes[i] = 8'h00;
         mirror_temp_bytes[i] = 8'h00;
      end
      repeat (12) @(negedge clock);
      reset = 1'b0;

      test_directed_sequences();
      test_fill_byte_extremes();
      test_random_traffic(0, 0, 420);
      test_random_traffic(86, 0, 420);
      test_random_traffic(0, 86, 420);
      test_random_traffic(12, 12, 420);

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[files.f]
hdl/spimsp_pkg.sv
hdl/spimsp_engine.sv
hdl/spi_multi_sensor_poll_sequencer.sv
dv/testbench.sv
